// File: rtl/core/lprc_pkg.sv
// Package for the linear probe result cache: sizes, mode codes, hash constants.
// No dependencies.
package lprc_pkg;
    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = SLOT_W + 1;
    localparam int ENTRY_W = 64 + 64 + 8;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_M1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2  = 64'h94d049bb133111eb;

    // Operations of the shared multiplier.
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_LH = 2'd1;
    localparam logic [1:0] MUL_HL = 2'd2;

    typedef struct packed {
        logic start;
        logic [63:0] key;
    } hash_req_t;

    typedef struct packed {
        logic done;
        logic [SLOT_W-1:0] home;
    } hash_rsp_t;
endpackage

// File: rtl/core/linear_probe_result_cache_top.sv
// Top level of the linear probe result cache: handshake, probe sequencer, slot memory.
// Depends on lprc_pkg, lprc_hash and lprc_ram.
//
// One word in gives one word out. The key is hashed on a shared 32x32
// multiplier (three partial products per multiply round), then slots are
// probed one at a time through the registered read of the slot RAM: each
// probe reads in S_READ and is checked in S_CHK. A clear or the unused mode
// skips the hash and the probes. A clear, and a store into a full table,
// sweeps the 64-entry valid array together, since validity is kept in
// flip-flops. No clearing pass is needed after reset. The input is not ready
// while a word is in work or a result waits.
module linear_probe_result_cache_top (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,   // key[63:0], store_value[127:64], store_type[135:128]
    input  logic [1:0]    s_tuser,   // mode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // found_value, found_type, hit_count, miss_count
    output logic          m_tuser    // hit
);
    import lprc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [63:0] key_reg, val_reg;
    logic [7:0]  typ_reg;
    logic [SLOT_W-1:0] home_reg, ptr_reg;
    logic [CNT_W-1:0]  probes_reg, occ_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [31:0] hitc_reg, missc_reg;
    logic        hit_reg;
    logic [63:0] fval_reg;
    logic [7:0]  ftyp_reg;
    hash_req_t   hreq;
    hash_rsp_t   hrsp;
    logic        we;
    logic [SLOT_W-1:0] addr;
    logic [ENTRY_W-1:0] rdata;
    logic        accept, full;
    logic        slot_v, slot_match, chain_end;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign full = (occ_reg == CNT_W'(TABLE_SLOTS));
    // Only lookups and stores use the hash unit.
    assign hreq.start = (state_reg == S_HASH) && !hrsp.done && (probes_reg == '0)
                        && (mode_reg == MODE_LOOKUP || mode_reg == MODE_STORE);
    assign hreq.key = key_reg;

    lprc_hash u_hash (.aclk(aclk), .aresetn(aresetn), .req(hreq), .rsp(hrsp));

    lprc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_ram (
        .aclk(aclk), .we(we), .addr(addr),
        .wdata({typ_reg, val_reg, key_reg}), .rdata(rdata));

    // Probe decision from the slot just read.
    assign slot_v = valid_reg[ptr_reg];
    assign slot_match = slot_v && (rdata[63:0] == key_reg);
    assign chain_end = (probes_reg == CNT_W'(TABLE_SLOTS - 1));
    assign addr = (state_reg == S_CHK && mode_reg == MODE_STORE && slot_v && !slot_match
                   && chain_end) ? home_reg : ptr_reg;
    assign we = (state_reg == S_CHK) && (mode_reg == MODE_STORE)
                && (!slot_v || slot_match || chain_end);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_HASH;
            S_HASH: begin
                if (mode_reg != MODE_LOOKUP && mode_reg != MODE_STORE) state_next = S_OUT;
                else if (hrsp.done) state_next = S_READ;
            end
            S_READ: state_next = S_CHK;
            S_CHK: begin
                if (!slot_v || slot_match || chain_end) state_next = S_OUT;
                else state_next = S_READ;
            end
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            occ_reg <= '0;
            hitc_reg <= '0;
            missc_reg <= '0;
            probes_reg <= '0;
        end else begin
            state_reg <= state_next;
            // Capture the word and clear result fields.
            if (accept) begin
                mode_reg <= s_tuser;
                key_reg <= s_tdata[63:0];
                val_reg <= s_tdata[127:64];
                typ_reg <= s_tdata[135:128];
                hit_reg <= 1'b0;
                fval_reg <= '0;
                ftyp_reg <= '0;
                probes_reg <= '0;
            end
            // Clear, and the pre-clear of a store into a full table.
            if (state_reg == S_HASH && probes_reg == '0) begin
                if (mode_reg == MODE_CLEAR || (mode_reg == MODE_STORE && full)) begin
                    valid_reg <= '0;
                    occ_reg <= '0;
                    hitc_reg <= '0;
                    missc_reg <= '0;
                end
                probes_reg <= CNT_W'(1);
            end
            if (state_reg == S_HASH && hrsp.done) begin
                home_reg <= hrsp.home;
                ptr_reg <= hrsp.home;
                probes_reg <= '0;
            end
            // Evaluate one probe.
            if (state_reg == S_CHK) begin
                if (mode_reg == MODE_LOOKUP) begin
                    if (slot_match) begin
                        hit_reg <= 1'b1;
                        fval_reg <= rdata[127:64];
                        ftyp_reg <= rdata[135:128];
                        if (hitc_reg != '1) hitc_reg <= hitc_reg + 32'd1;
                    end else if (!slot_v || chain_end) begin
                        if (missc_reg != '1) missc_reg <= missc_reg + 32'd1;
                    end
                end else if (!slot_v) begin
                    valid_reg[ptr_reg] <= 1'b1;
                    occ_reg <= occ_reg + CNT_W'(1);
                end
                ptr_reg <= ptr_reg + SLOT_W'(1);
                probes_reg <= probes_reg + CNT_W'(1);
            end
        end
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser = hit_reg;
    assign m_tdata = {missc_reg, hitc_reg, ftyp_reg, fval_reg};

    occ_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(TABLE_SLOTS))
        else $error("occupancy overflow");
    occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy mismatch");
    no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("ready while busy");
endmodule

// File: rtl/core/lprc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module lprc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read share one address.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/core/lprc_hash.sv
// Iterative splitmix64 home-slot hash over one shared 32x32 multiplier.
// Depends on lprc_pkg.
module lprc_hash (
    input  logic              aclk,
    input  logic              aresetn,
    input  lprc_pkg::hash_req_t req,
    output lprc_pkg::hash_rsp_t rsp
);
    import lprc_pkg::*;

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_MUL  = 3'd1;
    localparam logic [2:0] H_DONE = 3'd2;

    logic [2:0]  state_reg, state_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] m_reg, m_next;
    logic [1:0]  op_reg, op_next;
    logic        round_reg, round_next;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] xs;

    // The single shared multiplier.
    always_comb begin
        case (op_reg)
            MUL_LH: begin mul_a = x_reg[31:0];  mul_b = m_reg[63:32]; end
            MUL_HL: begin mul_a = x_reg[63:32]; mul_b = m_reg[31:0];  end
            default: begin mul_a = x_reg[31:0]; mul_b = m_reg[31:0];  end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
        xs = req.key + MIX_ADD;
    end

    // Each round takes three partial products: low by low, then the two cross terms.
    always_comb begin
        state_next = state_reg;
        x_next = x_reg;
        acc_next = acc_reg;
        m_next = m_reg;
        op_next = op_reg;
        round_next = round_reg;
        unique case (state_reg)
            H_IDLE: begin
                if (req.start) begin
                    x_next = xs ^ (xs >> 30);
                    m_next = MIX_M1;
                    op_next = MUL_LL;
                    round_next = 1'b0;
                    state_next = H_MUL;
                end
            end
            H_MUL: begin
                unique case (op_reg)
                    MUL_LL: begin acc_next = prod; op_next = MUL_LH; end
                    MUL_LH: begin
                        acc_next = acc_reg + {prod[31:0], 32'd0};
                        op_next = MUL_HL;
                    end
                    default: begin
                        acc_next = acc_reg + {prod[31:0], 32'd0};
                        op_next = MUL_LL;
                        if (!round_reg) begin
                            x_next = acc_next ^ (acc_next >> 27);
                            m_next = MIX_M2;
                            round_next = 1'b1;
                        end else begin
                            x_next = acc_next ^ (acc_next >> 31);
                            state_next = H_DONE;
                        end
                    end
                endcase
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
        end else begin
            state_reg <= state_next;
        end
        x_reg <= x_next;
        acc_reg <= acc_next;
        m_reg <= m_next;
        op_reg <= op_next;
        round_reg <= round_next;
    end

    assign rsp.done = (state_reg == H_DONE);
    assign rsp.home = x_reg[SLOT_W-1:0];

    hash_done_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done)
        else $error("hash done held");
    hash_state_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg <= H_DONE)
        else $error("hash state out of range");
    hash_start_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == H_IDLE && req.start) |=> (state_reg == H_MUL))
        else $error("hash start not taken");
endmodule
